// ----- sv/pce_pkg.sv -----
// Shared types, constants and widths for the pitch correlation energy block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package pce_pkg;

  // Storage and tap count
  localparam int BUF_DEPTH = 512;
  localparam int TAPS      = 20;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int CNT_W     = $clog2(TAPS + 1);

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int SIDX_W     = 9;
  localparam int SUBF_W     = 3;
  localparam int LAG_W      = 9;
  localparam int CORR_W     = 36;
  localparam int ENERGY_W   = 35;
  localparam int RIDX_W     = 12;

  // Configuration register widths and port
  localparam int BUF_LEN_W  = 10;
  localparam int STRIDE_W   = 10;
  localparam int NSUB_W     = 4;
  localparam int MINP_W     = 9;
  localparam int NLAGS_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Signed width that holds target and window start positions
  localparam int POS_W = 17;

  // Accumulator widths grow with the tap count
  localparam int ACC_W  = 32 + $clog2(TAPS);
  localparam int EACC_W = 31 + $clog2(TAPS);

  // Saturation compare widths, one bit above the wider side
  localparam int SAT_W  = ((ACC_W > CORR_W) ? ACC_W : CORR_W) + 1;
  localparam int ESAT_W = ((EACC_W > ENERGY_W) ? EACC_W : ENERGY_W) + 1;

  localparam logic signed [SAT_W-1:0] CORR_SAT_MAX =
    {{(SAT_W-CORR_W+1){1'b0}}, {(CORR_W-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] CORR_SAT_MIN =
    {{(SAT_W-CORR_W+1){1'b1}}, {(CORR_W-1){1'b0}}};
  localparam logic [ESAT_W-1:0] ENERGY_SAT_MAX =
    {{(ESAT_W-ENERGY_W){1'b0}}, {ENERGY_W{1'b1}}};

  // Reset values of the configuration registers
  localparam logic [BUF_LEN_W-1:0] BUF_LEN_RST = BUF_LEN_W'(512);
  localparam logic [STRIDE_W-1:0]  STRIDE_RST  = STRIDE_W'(40);
  localparam logic [NSUB_W-1:0]    NSUB_RST    = NSUB_W'(4);
  localparam logic [MINP_W-1:0]    MINP_RST    = MINP_W'(32);
  localparam logic [NLAGS_W-1:0]   NLAGS_RST   = NLAGS_W'(128);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic {
    REQ_LOAD    = 1'b0,
    REQ_COMPUTE = 1'b1
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUFFER_LENGTH   = 3'd0,
    CFG_SUBFRAME_STRIDE = 3'd1,
    CFG_NUM_SUBFRAMES   = 3'd2,
    CFG_MIN_PITCH       = 3'd3,
    CFG_NUM_LAGS        = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef enum logic {
    ERR_OK    = 1'b0,
    ERR_RANGE = 1'b1
  } err_code_e;

  // Control from the sequencer to the accumulator
  typedef struct packed {
    logic clear;
    logic acc_en;
  } mac_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/pce_if.sv -----
// Request and response channel interfaces with valid/ready handshake.
// Depends on pce_pkg for field widths.
`default_nettype none

interface pce_req_if import pce_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [SIDX_W-1:0]   sample_index;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic [SUBF_W-1:0]   subframe;
  logic [LAG_W-1:0]    lag;

  modport source (output valid, req_type, sample_index, sample_value, subframe, lag,
                  input ready);
  modport sink   (input valid, req_type, sample_index, sample_value, subframe, lag,
                  output ready);
endinterface

interface pce_rsp_if import pce_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [CORR_W-1:0]   correlation;
  logic [ENERGY_W-1:0]        energy;
  logic [RIDX_W-1:0]          result_index;
  logic                       error_code;

  modport source (output valid, correlation, energy, result_index, error_code,
                  input ready);
  modport sink   (input valid, correlation, energy, result_index, error_code,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/pce_sample_ram.sv -----
// Sample history memory: one write port, two registered read ports.
// Depends on pce_pkg for depth and sample type.
`default_nettype none

module pce_sample_ram import pce_pkg::*; (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire sample_t           wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr_a,
  input  wire logic [ADDR_W-1:0] raddr_b,
  output sample_t                rdata_a,
  output sample_t                rdata_b
);

  sample_t mem [BUF_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// ----- sv/pce_mac.sv -----
// Correlation and energy accumulators with output saturation.
// Depends on pce_pkg for widths and the mac_ctrl_t control group.
`default_nettype none

module pce_mac import pce_pkg::*; (
  input  wire logic               clk,
  input  wire mac_ctrl_t          ctrl,
  input  wire sample_t            tgt,
  input  wire sample_t            win,
  output logic signed [CORR_W-1:0] corr,
  output logic [ENERGY_W-1:0]     energy
);

  logic signed [ACC_W-1:0]  acc_c;
  logic [EACC_W-1:0]        acc_e;
  logic signed [31:0]       prod_c;
  logic signed [31:0]       prod_e;
  logic signed [SAT_W-1:0]  corr_x;
  logic [ESAT_W-1:0]        energy_x;

  assign prod_c = tgt * win;
  assign prod_e = tgt * tgt;

  // One tap per cycle while acc_en is set
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_c <= '0;
      acc_e <= '0;
    end else if (ctrl.acc_en) begin
      acc_c <= acc_c + ACC_W'(prod_c);
      acc_e <= acc_e + EACC_W'(prod_e[30:0]);
    end
  end

  // Clamp to the result ranges, energy floored at one
  assign corr_x   = SAT_W'(acc_c);
  assign energy_x = ESAT_W'(acc_e);

  always_comb begin
    if (corr_x > CORR_SAT_MAX) begin
      corr = CORR_W'(CORR_SAT_MAX);
    end else if (corr_x < CORR_SAT_MIN) begin
      corr = CORR_W'(CORR_SAT_MIN);
    end else begin
      corr = CORR_W'(corr_x);
    end

    if (energy_x > ENERGY_SAT_MAX) begin
      energy = ENERGY_W'(ENERGY_SAT_MAX);
    end else if (energy_x == '0) begin
      energy = ENERGY_W'(1);
    end else begin
      energy = ENERGY_W'(energy_x);
    end
  end

endmodule

`default_nettype wire

// ----- sv/pitch_correlation_energy.sv -----
// Pitch lag cross-correlation block: sequencer, configuration and result register.
// Depends on pce_pkg, pce_if, pce_sample_ram and pce_mac.
//
// Usage:
//   req channel: a load item (req_type 0) writes sample_value at sample_index
//   into the history memory and gives no result. A compute item (req_type 1)
//   names subframe and lag and gives one rsp item with the TAPS-tap
//   correlation, the target energy (at least one), the flat index and
//   error_code. A bad request gives error_code 1 and zero values.
//   A compute item passes through a setup state, TAPS memory reads with one
//   multiply-accumulate each, a drain state for the read latency and a done
//   state that registers the result; an error result skips the reads and the
//   drain. The req channel is ready only while the block is idle, so the next
//   compute item is taken only once the last one is through, and load items
//   are taken at one per cycle while the block is idle.
//   The result register lets the next item be accepted while a result waits;
//   a stalled rsp holds the block in its final step until the result is taken.
//   Reset (rst, synchronous) returns the configuration registers to their
//   defaults and empties the result register; memory contents are kept and
//   are undefined until loaded. The user must write configuration (cfg_we,
//   cfg_index, cfg_data) only while the block is idle; the block does not enforce it.
`default_nettype none

module pitch_correlation_energy import pce_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  pce_req_if.sink                    req,
  pce_rsp_if.source                  rsp,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [BUF_LEN_W-1:0] buf_len;
  logic [STRIDE_W-1:0]  stride;
  logic [NSUB_W-1:0]    nsub;
  logic [MINP_W-1:0]    min_pitch;
  logic [NLAGS_W-1:0]   num_lags;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_len   <= BUF_LEN_RST;
      stride    <= STRIDE_RST;
      nsub      <= NSUB_RST;
      min_pitch <= MINP_RST;
      num_lags  <= NLAGS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BUFFER_LENGTH:   buf_len   <= BUF_LEN_W'(cfg_data);
        CFG_SUBFRAME_STRIDE: stride    <= STRIDE_W'(cfg_data);
        CFG_NUM_SUBFRAMES:   nsub      <= NSUB_W'(cfg_data);
        CFG_MIN_PITCH:       min_pitch <= MINP_W'(cfg_data);
        CFG_NUM_LAGS:        num_lags  <= NLAGS_W'(cfg_data);
        default: ;
      endcase
    end
  end

  state_e state;
  state_e state_next;

  logic req_fire;
  logic load_we;
  logic out_load;
  logic rd_en;
  logic rd_vld;
  logic last_tap;
  mac_ctrl_t mac_ctrl;

  // Latched compute request
  logic [SUBF_W-1:0] subf;
  logic [LAG_W-1:0]  lag;

  // Setup results
  logic              err;
  logic [RIDX_W-1:0] ridx;
  logic [ADDR_W-1:0] taddr;
  logic [ADDR_W-1:0] waddr;
  logic [CNT_W-1:0]  cnt;

  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign load_we   = req_fire && (req.req_type == REQ_LOAD) &&
                     (32'(req.sample_index) < 32'(BUF_DEPTH));

  // Target and window positions from the configuration
  logic [13:0]      stride_x_nsub;
  logic [12:0]      sub_x_stride;
  logic [12:0]      sub_x_lags;
  logic [POS_W-1:0] t_calc;
  logic [POS_W-1:0] w_calc;
  logic [POS_W-1:0] t_end;
  logic             bad_req;

  assign stride_x_nsub = stride * nsub;
  assign sub_x_stride  = subf * stride;
  assign sub_x_lags    = subf * num_lags;
  assign t_calc = POS_W'(buf_len) - POS_W'(stride_x_nsub) + POS_W'(sub_x_stride);
  assign w_calc = t_calc - POS_W'(min_pitch) - POS_W'(lag);
  assign t_end  = t_calc + POS_W'(TAPS);

  assign bad_req = ({1'b0, subf} >= nsub) ||
                   ({1'b0, lag} >= num_lags) ||
                   (32'(buf_len) > 32'(BUF_DEPTH)) ||
                   t_calc[POS_W-1] ||
                   ($signed(t_end) > $signed(POS_W'(buf_len))) ||
                   w_calc[POS_W-1];

  assign last_tap = (cnt == CNT_W'(TAPS - 1));

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control
  always_comb begin
    state_next       = state;
    rd_en            = 1'b0;
    out_load         = 1'b0;
    mac_ctrl.clear   = 1'b0;
    mac_ctrl.acc_en  = rd_vld;
    unique case (state)
      ST_IDLE: begin
        if (req_fire && (req.req_type == REQ_COMPUTE)) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        mac_ctrl.clear = 1'b1;
        state_next     = bad_req ? ST_DONE : ST_RUN;
      end
      ST_RUN: begin
        rd_en = 1'b1;
        if (last_tap) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Read data valid in the cycle after each read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
    end
  end

  // Request latch, setup results and address walk
  always_ff @(posedge clk) begin
    if (req_fire) begin
      subf <= req.subframe;
      lag  <= req.lag;
    end
    if (state == ST_SETUP) begin
      err   <= bad_req;
      ridx  <= RIDX_W'(sub_x_lags + 13'(lag));
      taddr <= ADDR_W'(t_calc);
      waddr <= ADDR_W'(w_calc);
      cnt   <= '0;
    end else if (rd_en) begin
      taddr <= taddr + ADDR_W'(1);
      waddr <= waddr + ADDR_W'(1);
      cnt   <= cnt + CNT_W'(1);
    end
  end

  sample_t tgt;
  sample_t win;
  logic signed [CORR_W-1:0] corr_sat;
  logic [ENERGY_W-1:0]      energy_sat;

  pce_sample_ram u_ram (
    .clk     (clk),
    .we      (load_we),
    .waddr   (ADDR_W'(req.sample_index)),
    .wdata   (req.sample_value),
    .re      (rd_en),
    .raddr_a (taddr),
    .raddr_b (waddr),
    .rdata_a (tgt),
    .rdata_b (win)
  );

  pce_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .tgt    (tgt),
    .win    (win),
    .corr   (corr_sat),
    .energy (energy_sat)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (err) begin
        rsp.correlation  <= '0;
        rsp.energy       <= '0;
        rsp.result_index <= '0;
        rsp.error_code   <= ERR_RANGE;
      end else begin
        rsp.correlation  <= corr_sat;
        rsp.energy       <= energy_sat;
        rsp.result_index <= ridx;
        rsp.error_code   <= ERR_OK;
      end
    end
  end

endmodule

`default_nettype wire

// ----- test/correlation_checker.sv -----
`timescale 1ns / 1ps
// Checker for the pitch correlation block: keeps its own sample history and
// registers, predicts each compute result and compares what comes out.
// Depends on pce_pkg and the channel interfaces in pce_if.

module correlation_checker import pce_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  pce_req_if                    req,
  pce_rsp_if                    rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    outstanding,
  output int                    mismatches
);

  typedef struct packed {
    logic signed [CORR_W-1:0] correlation;
    logic [ENERGY_W-1:0]      energy;
    logic [RIDX_W-1:0]        result_index;
    err_code_e                error_code;
  } corr_result_t;

  localparam longint CORR_HI   = (longint'(1) << (CORR_W - 1)) - 1;
  localparam longint CORR_LO   = -(longint'(1) << (CORR_W - 1));
  localparam longint ENERGY_HI = (longint'(1) << ENERGY_W) - 1;

  // Mirror of the history memory and the registers
  sample_t              history [BUF_DEPTH];
  logic [BUF_LEN_W-1:0] buf_len;
  logic [STRIDE_W-1:0]  stride;
  logic [NSUB_W-1:0]    nsub;
  logic [MINP_W-1:0]    minp;
  logic [NLAGS_W-1:0]   nlags;

  corr_result_t pending_results [$];

  // Correlation, energy and flat index for one compute item
  function automatic corr_result_t predict_result(logic [SUBF_W-1:0] sf,
                                                  logic [LAG_W-1:0] lag);
    corr_result_t r;
    longint tgt_pos, win_pos, corr_sum, energy_sum, a, b, flat;
    r = '0;
    r.error_code = ERR_RANGE;
    tgt_pos = longint'(buf_len) - longint'(stride) * longint'(nsub)
              + longint'(sf) * longint'(stride);
    win_pos = tgt_pos - longint'(minp) - longint'(lag);
    if (sf >= nsub || lag >= nlags || buf_len > BUF_DEPTH || tgt_pos < 0 ||
        tgt_pos + TAPS > longint'(buf_len) || win_pos < 0)
      return r;
    corr_sum = 0;
    energy_sum = 0;
    for (int k = 0; k < TAPS; k++) begin
      a = history[tgt_pos + k];
      b = history[win_pos + k];
      corr_sum += a * b;
      energy_sum += a * a;
    end
    if (corr_sum > CORR_HI) corr_sum = CORR_HI;
    if (corr_sum < CORR_LO) corr_sum = CORR_LO;
    if (energy_sum > ENERGY_HI) energy_sum = ENERGY_HI;
    if (energy_sum < 1) energy_sum = 1;
    flat = longint'(sf) * longint'(nlags) + longint'(lag);
    r.correlation  = corr_sum[CORR_W-1:0];
    r.energy       = energy_sum[ENERGY_W-1:0];
    r.result_index = flat[RIDX_W-1:0];
    r.error_code   = ERR_OK;
    return r;
  endfunction

  initial begin
    outstanding = 0;
    mismatches  = 0;
  end

  always @(posedge clk) begin
    corr_result_t want;
    if (rst) begin
      buf_len = BUF_LEN_RST;
      stride  = STRIDE_RST;
      nsub    = NSUB_RST;
      minp    = MINP_RST;
      nlags   = NLAGS_RST;
      pending_results.delete();
    end else begin
      // Register writes; unknown indexes fall through
      if (cfg_we) begin
        case (cfg_index)
          CFG_BUFFER_LENGTH:   buf_len = cfg_data[BUF_LEN_W-1:0];
          CFG_SUBFRAME_STRIDE: stride  = cfg_data[STRIDE_W-1:0];
          CFG_NUM_SUBFRAMES:   nsub    = cfg_data[NSUB_W-1:0];
          CFG_MIN_PITCH:       minp    = cfg_data[MINP_W-1:0];
          CFG_NUM_LAGS:        nlags   = cfg_data[NLAGS_W-1:0];
          default: ;
        endcase
      end

      // Accepted request item
      if (req.valid && req.ready) begin
        if (req.req_type == REQ_LOAD)
          history[req.sample_index] = req.sample_value;
        else
          pending_results.push_back(predict_result(req.subframe, req.lag));
      end

      // Accepted result item against the oldest prediction
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: corr=%0d energy=%0d index=%0d err=%0d",
                   $time, rsp.correlation, rsp.energy, rsp.result_index,
                   rsp.error_code);
        end else begin
          want = pending_results.pop_front();
          if (rsp.correlation !== want.correlation || rsp.energy !== want.energy ||
              rsp.result_index !== want.result_index ||
              rsp.error_code !== want.error_code) begin
            mismatches++;
            $display("%0t: expected corr=%0d energy=%0d index=%0d err=%0d",
                     $time, want.correlation, want.energy, want.result_index,
                     want.error_code);
            $display("%0t:   actual corr=%0d energy=%0d index=%0d err=%0d",
                     $time, rsp.correlation, rsp.energy, rsp.result_index,
                     rsp.error_code);
          end
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

// ----- test/tb_pitch_correlation_energy.sv -----
`timescale 1ns / 1ps
// Top of the pitch correlation testbench: clock, reset, request stimulus,
// register phases and the verdict. Depends on pce_pkg, pce_if, the block
// and correlation_checker.

module tb_pitch_correlation_energy;
  import pce_pkg::*;

  localparam int SETTLE_CYCLES = TAPS + 5;

  typedef struct {
    int len;
    int stride;
    int nsub;
    int minp;
    int nlags;
    int items;
  } phase_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  idle_on;
  int                    outstanding;
  int                    mismatches;

  // Register values as last written, used to steer computes into range
  int cur_len, cur_stride, cur_nsub, cur_minp, cur_nlags;

  phase_t phases [10];

  pce_req_if req_ch ();
  pce_rsp_if rsp_ch ();

  pitch_correlation_energy dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  correlation_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Random result side back-pressure, started only while idle_on is set
  initial begin
    int stall_left;
    rsp_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 17);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Drive one request item and wait until it is taken
  task automatic send_item(req_type_e kind, logic [SIDX_W-1:0] idx, sample_t value,
                           logic [SUBF_W-1:0] sf, logic [LAG_W-1:0] lag);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= kind;
    req_ch.sample_index <= idx;
    req_ch.sample_value <= value;
    req_ch.subframe     <= sf;
    req_ch.lag          <= lag;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic send_load(int idx, sample_t value);
    send_item(REQ_LOAD, SIDX_W'(idx), value, SUBF_W'($urandom()), LAG_W'($urandom()));
  endtask

  task automatic send_compute(int sf, int lag);
    send_item(REQ_COMPUTE, SIDX_W'($urandom()), SAMPLE_W'($urandom()),
              SUBF_W'(sf), LAG_W'(lag));
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(negedge clk);
  endtask

  // Load with a bias toward full-scale and zero samples
  task automatic send_load_random();
    sample_t value;
    case ($urandom_range(0, 11))
      0: value = sample_t'(16'sh8000);
      1: value = sample_t'(16'sh7fff);
      2: value = '0;
      default: value = SAMPLE_W'($urandom());
    endcase
    send_load($urandom_range(0, BUF_DEPTH - 1), value);
  endtask

  // Mostly in-range computes, with the largest legal lag now and then
  task automatic send_compute_random();
    int sf, lag, tpos, max_lag, sf_count;
    sf  = $urandom_range(0, 7);
    lag = $urandom_range(0, 511);
    if ($urandom_range(0, 9) < 8 && cur_nsub != 0) begin
      sf_count = (cur_nsub > 8) ? 8 : cur_nsub;
      sf = $urandom_range(0, sf_count - 1);
      tpos = cur_len - cur_stride * cur_nsub + sf * cur_stride;
      max_lag = tpos - cur_minp;
      if (max_lag > cur_nlags - 1) max_lag = cur_nlags - 1;
      if (max_lag > 511) max_lag = 511;
      if (max_lag >= 0)
        lag = ($urandom_range(0, 3) == 0) ? max_lag : $urandom_range(0, max_lag);
    end
    send_compute(sf, lag);
  endtask

  task automatic run_random(int count, bit last_part);
    for (int n = 0; n < count; n++) begin
      if (last_part) idle_on = 1'b0;
      else if (n % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 149) == 0) drain_results();
      if ($urandom_range(0, 1) == 0) send_compute_random();
      else send_load_random();
    end
  endtask

  // Timeout guard
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    sample_t value;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    idle_on             = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.req_type     = REQ_LOAD;
    req_ch.sample_index = '0;
    req_ch.sample_value = '0;
    req_ch.subframe     = '0;
    req_ch.lag          = '0;
    cur_len    = int'(BUF_LEN_RST);
    cur_stride = int'(STRIDE_RST);
    cur_nsub   = int'(NSUB_RST);
    cur_minp   = int'(MINP_RST);
    cur_nlags  = int'(NLAGS_RST);

    //              len   stride nsub minp nlags items
    phases[0] = '{512,  1,    8,   0,   512,  100};  // smallest stride and pitch
    phases[1] = '{20,   20,   1,   0,   1,    40};   // shortest buffer, one lag
    phases[2] = '{512,  5,    4,   0,   512,  50};   // targets run past the end
    phases[3] = '{512,  64,   1,   511, 64,   30};   // window always before start
    phases[4] = '{1023, 40,   4,   32,  128,  30};   // length beyond the memory
    phases[5] = '{512,  20,   8,   100, 1000, 80};   // flat index wraps
    phases[6] = '{500,  30,   15,  5,   50,   80};   // more subframes than fit
    phases[7] = '{512,  40,   0,   32,  128,  24};   // no subframes
    phases[8] = '{512,  1023, 1,   0,   1023, 24};   // target before start
    phases[9] = '{512,  40,   4,   32,  128,  216};  // defaults, no idling

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fill the whole history; fixed patterns around the default targets:
    // subframe 0 target at full negative scale, subframe 1 target silent,
    // lag 0 window at full positive scale, lag 32 window at full negative scale
    for (int i = 0; i < BUF_DEPTH; i++) begin
      if ((i >= 352 && i < 372) || (i >= 288 && i < 308)) value = sample_t'(16'sh8000);
      else if (i >= 320 && i < 340) value = sample_t'(16'sh7fff);
      else if (i >= 392 && i < 412) value = '0;
      else value = SAMPLE_W'($urandom());
      send_load(i, value);
    end

    // Directed items under the reset settings
    send_compute(0, 0);      // largest negative correlation, largest energy
    send_compute(0, 32);     // largest positive correlation
    send_compute(1, 0);      // silent target, energy floored at one
    send_compute(3, 127);    // last subframe, last lag
    send_compute(0, 128);    // lag past the lag count
    send_compute(4, 0);      // subframe past the subframe count
    send_compute(7, 511);    // all field bits set
    send_load(511, sample_t'(16'sh7fff));
    send_load(0, sample_t'(16'sh8000));
    send_load(9'h155, sample_t'(16'sh5555));
    send_load(9'h0aa, sample_t'(16'shaaaa));
    send_compute(2, 0);
    send_compute(3, 0);
    send_compute(2, 64);

    // Register phases, each written with nothing in flight
    for (int p = 0; p < 10; p++) begin
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clk);
      if (p == 0) begin
        for (int i = int'(CFG_NUM_LAGS) + 1; i < 2 ** CFG_IDX_W; i++)
          write_reg(CFG_IDX_W'(i), $urandom());
      end
      write_reg(CFG_BUFFER_LENGTH, phases[p].len);
      write_reg(CFG_SUBFRAME_STRIDE, phases[p].stride);
      write_reg(CFG_NUM_SUBFRAMES, phases[p].nsub);
      write_reg(CFG_MIN_PITCH, phases[p].minp);
      write_reg(CFG_NUM_LAGS, phases[p].nlags);
      cfg_we <= 1'b0;
      cur_len    = phases[p].len;
      cur_stride = phases[p].stride;
      cur_nsub   = phases[p].nsub;
      cur_minp   = phases[p].minp;
      cur_nlags  = phases[p].nlags;
      run_random(phases[p].items, p == 9);
    end

    // Wind down and give the verdict
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
